// File: hdl/occ_pkg.sv
// ----------------------------------------------------------------------------
// Oklab color converter package
// Shared widths, fixed-point constants, bus types and the table generators
// that fill the log and gamma lookup tables at elaboration.
// ----------------------------------------------------------------------------
package occ_pkg;

    localparam int GAMMA_DEPTH_DEF = 1024;
    localparam int LOG_DEPTH_DEF   = 256;

    localparam int LAB_W      = 16;
    localparam int DISP_W     = 16;
    localparam int PIX_W      = 16;
    localparam int LMS_W      = 32;
    localparam int LIN_W      = 25;
    localparam int ROM_W      = 21;
    localparam int LAB_COEF_W = 18;
    localparam int RGB_COEF_W = 20;

    localparam int DISP_FRAC = 15;
    localparam int LIN_FRAC  = 24;
    localparam int CM_FRAC   = 22;
    localparam int POW_FRAC  = 30;

    localparam logic [DISP_W-1:0] DISP_ONE  = 16'd32768;
    localparam logic [LIN_W-1:0]  LIN_ONE   = 25'd16777216;
    localparam logic [LIN_W-1:0]  LIN_LIMIT = 25'd52526;

    localparam int LIN_GAIN_W = 20;
    localparam int POW_GAIN_W = 27;
    localparam logic [LIN_GAIN_W-1:0] LIN_GAIN   = 20'd846712;
    localparam logic [POW_GAIN_W-1:0] POW_GAIN   = 27'd70798771;
    localparam logic [11:0]           POW_OFFSET = 12'd3604;

    // Colormap: L = 0.15 + 0.70 f, a = -0.05 + 0.08 f, b = -0.10 + 0.20 f.
    localparam int CM_GAIN_W = 16;
    localparam int CM_SUM_W  = 40;
    localparam logic [CM_GAIN_W-1:0] CM_GAIN_L = 16'd45875;
    localparam logic [CM_GAIN_W-1:0] CM_GAIN_A = 16'd5243;
    localparam logic [CM_GAIN_W-1:0] CM_GAIN_B = 16'd13107;
    localparam logic signed [CM_SUM_W-1:0] CM_BASE_L = 40'sd10307921510;
    localparam logic signed [CM_SUM_W-1:0] CM_BASE_A = -40'sd3435973837;
    localparam logic signed [CM_SUM_W-1:0] CM_BASE_B = -40'sd6871947674;
    localparam logic signed [CM_SUM_W-1:0] CM_HALF   = 40'sd2097152;

    // Oklab to cube-root LMS, Q16 (the L column is unity).
    localparam logic signed [LAB_COEF_W-1:0] LAB_COEF [3][2] = '{
        '{ 18'sd25974,  18'sd14143},
        '{-18'sd6918,  -18'sd4185},
        '{-18'sd5864,  -18'sd84639}
    };

    // LMS to linear sRGB, Q16.
    localparam logic signed [RGB_COEF_W-1:0] RGB_COEF [3][3] = '{
        '{ 20'sd267173, -20'sd216774,  20'sd15137},
        '{-20'sd83128,   20'sd171033, -20'sd22369},
        '{-20'sd275,    -20'sd46099,   20'sd111910}
    };

    typedef struct packed {
        logic signed [LAB_W-1:0] l;
        logic signed [LAB_W-1:0] a;
        logic signed [LAB_W-1:0] b;
    } lab_t;

    typedef struct packed {
        logic signed [LMS_W-1:0] l;
        logic signed [LMS_W-1:0] m;
        logic signed [LMS_W-1:0] s;
    } lms_t;

    typedef struct packed {
        logic [LIN_W-1:0] r;
        logic [LIN_W-1:0] g;
        logic [LIN_W-1:0] b;
    } lin_rgb_t;

    localparam logic [63:0] ONE20    = 64'h0000_0000_0010_0000;
    localparam logic [63:0] ONE30    = 64'h0000_0000_4000_0000;
    localparam logic [63:0] E_M1_Q30 =
        ((64'd1718281828 << 30) + 64'd500000000) / 64'd1000000000;

    // Restoring long division, used only while building the tables.
    function automatic logic [63:0] udiv(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [63:0] r;
        q = '0;
        r = '0;
        for (int k = 63; k >= 0; k--)
        begin
            r = {r[62:0], n[k]};
            if (r >= d)
            begin
                r    = r - d;
                q[k] = 1'b1;
            end
        end
        return q;
    endfunction

    // Floor of the square or cube root by bisection.
    function automatic logic [63:0] root_floor(input logic [63:0] n, input logic cube);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] mid;
        logic [63:0] pw;
        lo = '0;
        hi = 64'd1 << 21;
        for (int k = 0; k < 22; k++)
        begin
            if (hi - lo > 64'd1)
            begin
                mid = (lo + hi) >> 1;
                pw  = cube ? mid * mid * mid : mid * mid;
                if (pw <= n)
                    lo = mid;
                else
                    hi = mid;
            end
        end
        return lo;
    endfunction

    // Node i of the x^(5/12) table in Q20.
    function automatic logic [ROM_W-1:0] gamma_entry(input int unsigned i,
                                                     input int unsigned depth);
        logic [63:0] x;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] s;
        logic [63:0] p;
        x = udiv(64'(i) << 20, 64'(depth));
        q = root_floor(x << 40, 1'b1);
        r = root_floor(q << 20, 1'b0);
        s = root_floor(r << 20, 1'b0);
        p = (q * s + (ONE20 >> 1)) >> 20;
        return (p > ONE20) ? ONE20[ROM_W-1:0] : p[ROM_W-1:0];
    endfunction

    // Node j of the ln(1 + t(e-1)) table in Q20, via the atanh series.
    function automatic logic [ROM_W-1:0] log_entry(input int unsigned j,
                                                   input int unsigned depth);
        logic [63:0] t;
        logic [63:0] y;
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] f;
        t    = udiv(64'(j) << 30, 64'(depth));
        y    = ONE30 + ((t * E_M1_Q30) >> 30);
        z    = udiv((y - ONE30) << 30, y + ONE30);
        z2   = (z * z) >> 30;
        term = z;
        sum  = '0;
        for (int k = 0; k < 24; k++)
        begin
            sum  = sum + udiv(term, 64'(2 * k + 1));
            term = (term * z2) >> 30;
        end
        f = ((sum << 1) + 64'd512) >> 10;
        return (f > ONE20) ? ONE20[ROM_W-1:0] : f[ROM_W-1:0];
    endfunction

endpackage

// File: hdl/occ_log_map.sv
// ----------------------------------------------------------------------------
// Colormap front end
// Maps the display scalar through the interpolated log table into Oklab and
// selects between that and the incoming Oklab triple. Six stages.
// ----------------------------------------------------------------------------
module occ_log_map #(
    parameter int LOG_DEPTH = occ_pkg::LOG_DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       valid_in,
    input  logic                       req_type,
    input  occ_pkg::lab_t              lab_in,
    input  logic [occ_pkg::DISP_W-1:0] display_level,
    output logic                       valid_out,
    output occ_pkg::lab_t              lab_out
);
    import occ_pkg::*;

    localparam int NODE_W = $clog2(LOG_DEPTH + 1);
    localparam int POS_W  = DISP_W + NODE_W;
    localparam int PROD_W = ROM_W + DISP_FRAC;
    localparam int CMP_W  = CM_GAIN_W + ROM_W;
    localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(LOG_DEPTH);

    logic [ROM_W-1:0] rom [LOG_DEPTH+1];

    for (genvar gi = 0; gi <= LOG_DEPTH; gi++)
    begin : g_rom
        localparam logic [ROM_W-1:0] ENTRY = log_entry(gi, LOG_DEPTH);
        assign rom[gi] = ENTRY;
    end

    logic [DISP_W-1:0]    t_clamp;
    logic [POS_W-1:0]     pos;
    logic [NODE_W-1:0]    node;
    logic [NODE_W-1:0]    node_hi;

    logic [5:0]           valid_reg;
    logic [4:0]           type_reg;
    lab_t                 lab1_reg;
    lab_t                 lab2_reg;
    lab_t                 lab3_reg;
    lab_t                 lab4_reg;
    lab_t                 lab5_reg;
    lab_t                 lab6_reg;
    lab_t                 lab6_next;
    logic [NODE_W-1:0]    idx0_reg;
    logic [NODE_W-1:0]    idx1_reg;
    logic [DISP_FRAC-1:0] frac1_reg;
    logic [DISP_FRAC-1:0] frac2_reg;
    logic [ROM_W-1:0]     lo2_reg;
    logic [ROM_W-1:0]     hi2_reg;
    logic [ROM_W-1:0]     lo3_reg;
    logic [PROD_W-1:0]    prod3_reg;
    logic [ROM_W-1:0]     f4_reg;
    logic [CMP_W-1:0]     pl5_reg;
    logic [CMP_W-1:0]     pa5_reg;
    logic [CMP_W-1:0]     pb5_reg;

    logic signed [CM_SUM_W-1:0] sum_l;
    logic signed [CM_SUM_W-1:0] sum_a;
    logic signed [CM_SUM_W-1:0] sum_b;

    assign t_clamp = (display_level > DISP_ONE) ? DISP_ONE : display_level;
    assign pos     = POS_W'(t_clamp) * POS_W'(LOG_DEPTH);
    assign node    = pos[DISP_FRAC +: NODE_W];
    // The top node has no right neighbor; its fraction is zero there anyway.
    assign node_hi = (node == LAST_NODE) ? node : node + 1'b1;

    assign sum_l = CM_BASE_L + CM_SUM_W'(signed'({1'b0, pl5_reg})) + CM_HALF;
    assign sum_a = CM_BASE_A + CM_SUM_W'(signed'({1'b0, pa5_reg})) + CM_HALF;
    assign sum_b = CM_BASE_B + CM_SUM_W'(signed'({1'b0, pb5_reg})) + CM_HALF;

    always_comb
    begin
        if (type_reg[4])
        begin
            lab6_next.l = sum_l[CM_FRAC +: LAB_W];
            lab6_next.a = sum_a[CM_FRAC +: LAB_W];
            lab6_next.b = sum_b[CM_FRAC +: LAB_W];
        end
        else
        begin
            lab6_next = lab5_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[4:0], valid_in};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            type_reg  <= {type_reg[3:0], req_type};
            lab1_reg  <= lab_in;
            lab2_reg  <= lab1_reg;
            lab3_reg  <= lab2_reg;
            lab4_reg  <= lab3_reg;
            lab5_reg  <= lab4_reg;
            lab6_reg  <= lab6_next;
            idx0_reg  <= node;
            idx1_reg  <= node_hi;
            frac1_reg <= pos[DISP_FRAC-1:0];
            lo2_reg   <= rom[idx0_reg];
            hi2_reg   <= rom[idx1_reg];
            frac2_reg <= frac1_reg;
            lo3_reg   <= lo2_reg;
            prod3_reg <= PROD_W'(hi2_reg - lo2_reg) * PROD_W'(frac2_reg);
            f4_reg    <= lo3_reg + ROM_W'(prod3_reg >> DISP_FRAC);
            pl5_reg   <= CMP_W'(CM_GAIN_L) * CMP_W'(f4_reg);
            pa5_reg   <= CMP_W'(CM_GAIN_A) * CMP_W'(f4_reg);
            pb5_reg   <= CMP_W'(CM_GAIN_B) * CMP_W'(f4_reg);
        end
    end

    assign valid_out = valid_reg[5];
    assign lab_out   = lab6_reg;

endmodule

// File: hdl/occ_lms.sv
// ----------------------------------------------------------------------------
// Oklab to LMS
// First matrix and the cube of each LMS component, three lanes, four stages.
// ----------------------------------------------------------------------------
module occ_lms (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          valid_in,
    input  occ_pkg::lab_t lab_in,
    output logic          valid_out,
    output occ_pkg::lms_t lms_out
);
    import occ_pkg::*;

    localparam int X_W     = 18;
    localparam int LPROD_W = LAB_COEF_W + LAB_W;
    localparam int LSUM_W  = LPROD_W + 1;
    localparam int SQ_W    = 2 * X_W;
    localparam int CUBE_W  = SQ_W + X_W;
    localparam logic signed [LSUM_W-1:0] LSUM_HALF = LSUM_W'(32768);
    localparam logic signed [CUBE_W-1:0] CUBE_HALF = CUBE_W'(131072);

    logic [3:0]                valid_reg;
    logic signed [LAB_W-1:0]   l1_reg;
    logic signed [LPROD_W-1:0] p0_reg [3];
    logic signed [LPROD_W-1:0] p1_reg [3];
    logic signed [X_W-1:0]     x_reg [3];
    logic signed [X_W-1:0]     xd_reg [3];
    logic signed [SQ_W-1:0]    sq_reg [3];
    logic signed [LMS_W-1:0]   lms_reg [3];
    logic signed [LSUM_W-1:0]  lsum [3];
    logic signed [CUBE_W-1:0]  cube [3];

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            lsum[k] = LSUM_W'(p0_reg[k]) + LSUM_W'(p1_reg[k]) + LSUM_HALF;
            cube[k] = CUBE_W'(sq_reg[k]) * CUBE_W'(xd_reg[k]) + CUBE_HALF;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[2:0], valid_in};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            l1_reg <= lab_in.l;
            for (int k = 0; k < 3; k++)
            begin
                p0_reg[k]  <= LPROD_W'(LAB_COEF[k][0]) * LPROD_W'(lab_in.a);
                p1_reg[k]  <= LPROD_W'(LAB_COEF[k][1]) * LPROD_W'(lab_in.b);
                x_reg[k]   <= X_W'(l1_reg) + X_W'(lsum[k] >>> 16);
                sq_reg[k]  <= SQ_W'(x_reg[k]) * SQ_W'(x_reg[k]);
                xd_reg[k]  <= x_reg[k];
                lms_reg[k] <= LMS_W'(cube[k] >>> 18);
            end
        end
    end

    assign valid_out = valid_reg[3];
    assign lms_out.l = lms_reg[0];
    assign lms_out.m = lms_reg[1];
    assign lms_out.s = lms_reg[2];

endmodule

// File: hdl/occ_rgb.sv
// ----------------------------------------------------------------------------
// LMS to linear sRGB
// Second matrix, rounding and clamping to [0, 1] in Q24. Two stages.
// ----------------------------------------------------------------------------
module occ_rgb (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              valid_in,
    input  occ_pkg::lms_t     lms_in,
    output logic              valid_out,
    output occ_pkg::lin_rgb_t lin_out
);
    import occ_pkg::*;

    localparam int RPROD_W = RGB_COEF_W + LMS_W;
    localparam int ACC_W   = RPROD_W + 2;
    localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(32768);
    localparam logic signed [ACC_W-1:0] ACC_ONE  = ACC_W'(signed'({1'b0, LIN_ONE}));

    logic [1:0]                valid_reg;
    logic signed [RPROD_W-1:0] prod_reg [3][3];
    logic [LIN_W-1:0]          lin_reg [3];
    logic signed [LMS_W-1:0]   lms_vec [3];
    logic signed [ACC_W-1:0]   acc [3];
    logic signed [ACC_W-1:0]   rnd_v [3];
    logic [LIN_W-1:0]          lin_next [3];

    assign lms_vec[0] = lms_in.l;
    assign lms_vec[1] = lms_in.m;
    assign lms_vec[2] = lms_in.s;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            acc[k]   = ACC_W'(prod_reg[k][0]) + ACC_W'(prod_reg[k][1])
                     + ACC_W'(prod_reg[k][2]) + ACC_HALF;
            rnd_v[k] = acc[k] >>> 16;
            if (rnd_v[k] < 0)
                lin_next[k] = '0;
            else if (rnd_v[k] > ACC_ONE)
                lin_next[k] = LIN_ONE;
            else
                lin_next[k] = rnd_v[k][LIN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[0], valid_in};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    prod_reg[k][j] <= RPROD_W'(RGB_COEF[k][j]) * RPROD_W'(lms_vec[j]);
                end
                lin_reg[k] <= lin_next[k];
            end
        end
    end

    assign valid_out = valid_reg[1];
    assign lin_out.r = lin_reg[0];
    assign lin_out.g = lin_reg[1];
    assign lin_out.b = lin_reg[2];

endmodule

// File: hdl/occ_gamma.sv
// ----------------------------------------------------------------------------
// sRGB transfer curve, one channel
// Linear segment near black, interpolated x^(5/12) table above it, then
// scaling, offset and clamping to 16 bits. Six stages, own table copy.
// ----------------------------------------------------------------------------
module occ_gamma #(
    parameter int GAMMA_DEPTH = occ_pkg::GAMMA_DEPTH_DEF
) (
    input  logic                      clk,
    input  logic                      en,
    input  logic [occ_pkg::LIN_W-1:0] lin,
    output logic [occ_pkg::PIX_W-1:0] pix
);
    import occ_pkg::*;

    localparam int NODE_W  = $clog2(GAMMA_DEPTH + 1);
    localparam int POS_W   = LIN_W + NODE_W;
    localparam int LPROD_W = LIN_W + LIN_GAIN_W;
    localparam int DPROD_W = ROM_W + LIN_FRAC;
    localparam int MPROD_W = ROM_W + POW_GAIN_W;
    localparam int VAL_W   = MPROD_W - POW_FRAC;
    localparam int RES_W   = VAL_W + 1;
    localparam logic [NODE_W-1:0]  LAST_NODE = NODE_W'(GAMMA_DEPTH);
    localparam logic [LPROD_W-1:0] LIN_HALF  = LPROD_W'(1) << (LIN_FRAC - 1);
    localparam logic [MPROD_W-1:0] POW_HALF  = MPROD_W'(1) << (POW_FRAC - 1);

    logic [ROM_W-1:0] rom [GAMMA_DEPTH+1];

    for (genvar gi = 0; gi <= GAMMA_DEPTH; gi++)
    begin : g_rom
        localparam logic [ROM_W-1:0] ENTRY = gamma_entry(gi, GAMMA_DEPTH);
        assign rom[gi] = ENTRY;
    end

    logic [POS_W-1:0]        pos;
    logic [NODE_W-1:0]       node;
    logic [NODE_W-1:0]       node_hi;
    logic [LPROD_W-1:0]      lin_rnd;
    logic [VAL_W-1:0]        val;
    logic signed [RES_W-1:0] res;

    logic [NODE_W-1:0]   idx0_reg;
    logic [NODE_W-1:0]   idx1_reg;
    logic [LIN_FRAC-1:0] frac1_reg;
    logic [LIN_FRAC-1:0] frac2_reg;
    logic [LPROD_W-1:0]  linp1_reg;
    logic [4:0]          sel_reg;
    logic [PIX_W-1:0]    linv2_reg;
    logic [PIX_W-1:0]    linv3_reg;
    logic [PIX_W-1:0]    linv4_reg;
    logic [PIX_W-1:0]    linv5_reg;
    logic [ROM_W-1:0]    lo2_reg;
    logic [ROM_W-1:0]    hi2_reg;
    logic [ROM_W-1:0]    lo3_reg;
    logic [DPROD_W-1:0]  prod3_reg;
    logic [ROM_W-1:0]    p4_reg;
    logic [MPROD_W-1:0]  m5_reg;
    logic [PIX_W-1:0]    pix_reg;
    logic [PIX_W-1:0]    pix_next;

    assign pos     = POS_W'(lin) * POS_W'(GAMMA_DEPTH);
    assign node    = pos[LIN_FRAC +: NODE_W];
    assign node_hi = (node == LAST_NODE) ? node : node + 1'b1;
    assign lin_rnd = (linp1_reg + LIN_HALF) >> LIN_FRAC;

    assign val = VAL_W'((m5_reg + POW_HALF) >> POW_FRAC);
    assign res = signed'(RES_W'(val)) - signed'(RES_W'(POW_OFFSET));

    always_comb
    begin
        if (sel_reg[4])
            pix_next = linv5_reg;
        else if (res[RES_W-1])
            pix_next = '0;
        else if (res[RES_W-2:PIX_W] != '0)
            pix_next = '1;
        else
            pix_next = res[PIX_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            idx0_reg  <= node;
            idx1_reg  <= node_hi;
            frac1_reg <= pos[LIN_FRAC-1:0];
            linp1_reg <= LPROD_W'(lin) * LPROD_W'(LIN_GAIN);
            sel_reg   <= {sel_reg[3:0], (lin <= LIN_LIMIT)};
            lo2_reg   <= rom[idx0_reg];
            hi2_reg   <= rom[idx1_reg];
            frac2_reg <= frac1_reg;
            linv2_reg <= lin_rnd[PIX_W-1:0];
            linv3_reg <= linv2_reg;
            linv4_reg <= linv3_reg;
            linv5_reg <= linv4_reg;
            lo3_reg   <= lo2_reg;
            prod3_reg <= DPROD_W'(hi2_reg - lo2_reg) * DPROD_W'(frac2_reg);
            p4_reg    <= lo3_reg + ROM_W'(prod3_reg >> LIN_FRAC);
            m5_reg    <= MPROD_W'(p4_reg) * MPROD_W'(POW_GAIN);
            pix_reg   <= pix_next;
        end
    end

    assign pix = pix_reg;

endmodule

// File: hdl/oklab_to_srgb_converter.sv
// ----------------------------------------------------------------------------
// Oklab to sRGB converter
// Throughput: one item per cycle while the output is not stalled; every stage is a plain register stage.
// Reset clears only the stage valid bits; tables are constants.
// A stalled output freezes the whole pipeline, so nothing is lost.
// ----------------------------------------------------------------------------
module oklab_to_srgb_converter #(
    parameter int GAMMA_TABLE_DEPTH = occ_pkg::GAMMA_DEPTH_DEF,
    parameter int LOG_TABLE_DEPTH   = occ_pkg::LOG_DEPTH_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  logic                              req_type,
    input  logic signed [occ_pkg::LAB_W-1:0]  lightness,
    input  logic signed [occ_pkg::LAB_W-1:0]  axis_green_red,
    input  logic signed [occ_pkg::LAB_W-1:0]  axis_blue_yellow,
    input  logic [occ_pkg::DISP_W-1:0]        display_level,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output logic [occ_pkg::PIX_W-1:0]         red,
    output logic [occ_pkg::PIX_W-1:0]         green,
    output logic [occ_pkg::PIX_W-1:0]         blue
);
    import occ_pkg::*;

    // The pipeline runs as one unit. It advances in every cycle except when
    // a finished result sits in the output register and the far side stalls.
    // Then the input side is stalled too, so an item is never dropped.
    logic     en;
    lab_t     lab_in;
    logic     map_valid;
    lab_t     map_lab;
    logic     lms_valid;
    lms_t     lms;
    logic     lin_valid;
    lin_rgb_t lin;
    logic [5:0] enc_valid_reg;

    assign en        = !(rsp_valid && rsp_stall);
    assign req_stall = !en;

    assign lab_in.l = lightness;
    assign lab_in.a = axis_green_red;
    assign lab_in.b = axis_blue_yellow;

    // Stage group 1: the display scalar goes through the log table and the
    // colormap line; the Oklab triple rides alongside and one is selected.
    occ_log_map #(
        .LOG_DEPTH (LOG_TABLE_DEPTH)
    ) u_log_map (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (en),
        .valid_in      (req_valid),
        .req_type      (req_type),
        .lab_in        (lab_in),
        .display_level (display_level),
        .valid_out     (map_valid),
        .lab_out       (map_lab)
    );

    // Stage group 2: first matrix and cubing into LMS.
    occ_lms u_lms (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (map_valid),
        .lab_in    (map_lab),
        .valid_out (lms_valid),
        .lms_out   (lms)
    );

    // Stage group 3: second matrix and clamping of linear RGB.
    occ_rgb u_rgb (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .valid_in  (lms_valid),
        .lms_in    (lms),
        .valid_out (lin_valid),
        .lin_out   (lin)
    );

    // Stage group 4: the transfer curve. Each channel has its own table so
    // every table is read at only two addresses per cycle. The valid bits
    // for these six stages are kept here since the lanes share them.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enc_valid_reg <= '0;
        end
        else if (en)
        begin
            enc_valid_reg <= {enc_valid_reg[4:0], lin_valid};
        end
    end

    occ_gamma #(
        .GAMMA_DEPTH (GAMMA_TABLE_DEPTH)
    ) u_gamma_r (
        .clk (clk),
        .en  (en),
        .lin (lin.r),
        .pix (red)
    );

    occ_gamma #(
        .GAMMA_DEPTH (GAMMA_TABLE_DEPTH)
    ) u_gamma_g (
        .clk (clk),
        .en  (en),
        .lin (lin.g),
        .pix (green)
    );

    occ_gamma #(
        .GAMMA_DEPTH (GAMMA_TABLE_DEPTH)
    ) u_gamma_b (
        .clk (clk),
        .en  (en),
        .lin (lin.b),
        .pix (blue)
    );

    assign rsp_valid = enc_valid_reg[5];

    // A result leaves the output register only through a transfer.
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(rsp_valid) |-> $past(!rsp_stall))
        else $error("result lost without a transfer");

    // While the output is held, no new item may enter the pipeline.
    a_hold_input: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_stall) |-> !(req_valid && !req_stall))
        else $error("input accepted while the pipeline is frozen");

endmodule

// File: bench/oklab_to_srgb_converter_tb.sv
// ----------------------------------------------------------------------------
// Oklab to sRGB converter testbench
// Drives Oklab triples and colormap scalars into the converter with random
// gaps on both channels, predicts every pixel in fixed point, and compares
// each returned pixel against the oldest pending prediction.
// ----------------------------------------------------------------------------
module oklab_to_srgb_converter_tb;

    import occ_pkg::*;

    localparam int GAMMA_TABLE_DEPTH = 1024;
    localparam int LOG_TABLE_DEPTH   = 256;
    localparam int RANDOM_ITEMS      = 1000;
    localparam int QUIET_TAIL        = 100;
    localparam int HOLD_CYCLES       = 200;
    localparam int WATCHDOG_LIMIT    = 4000;
    localparam int DRAIN_CYCLES      = 40;

    localparam logic REQ_OKLAB    = 1'b0;
    localparam logic REQ_COLORMAP = 1'b1;

    // The scoreboard owns the fixed-point pixel predictor, its two tables and
    // the queue of pixels that the converter still owes us.
    class pixel_scoreboard;
        typedef struct {
            logic [15:0] r;
            logic [15:0] g;
            logic [15:0] b;
        } pixel_t;

        longint gamma_tab[GAMMA_TABLE_DEPTH+1];
        longint log_tab[LOG_TABLE_DEPTH+1];
        longint lab_c[3][2];
        longint rgb_c[3][3];
        pixel_t owed[$];
        int     errors;
        int     checked;

        function new();
            longint unsigned x, q, r, s, p, t, y, f, e1;
            errors  = 0;
            checked = 0;
            lab_c[0][0] =  q16(64'd3963377774);  lab_c[0][1] =  q16(64'd2158037573);
            lab_c[1][0] = -q16(64'd1055613458);  lab_c[1][1] = -q16(64'd638541728);
            lab_c[2][0] = -q16(64'd894841775);   lab_c[2][1] = -q16(64'd12914855480);
            rgb_c[0][0] =  q16(64'd40767416621); rgb_c[0][1] = -q16(64'd33077115913);
            rgb_c[0][2] =  q16(64'd2309699292);
            rgb_c[1][0] = -q16(64'd12684380046); rgb_c[1][1] =  q16(64'd26097574011);
            rgb_c[1][2] = -q16(64'd3413193965);
            rgb_c[2][0] = -q16(64'd41960863);    rgb_c[2][1] = -q16(64'd7034186147);
            rgb_c[2][2] =  q16(64'd17076147010);
            for (int i = 0; i <= GAMMA_TABLE_DEPTH; i++)
            begin
                x = (longint'(i) << 20) / GAMMA_TABLE_DEPTH;
                q = floor_root(x << 40, 1'b1);
                r = floor_root(q << 20, 1'b0);
                s = floor_root(r << 20, 1'b0);
                p = (q * s + 64'd524288) >> 20;
                gamma_tab[i] = (p > 64'd1048576) ? 64'd1048576 : p;
            end
            e1 = ((64'd1718281828 << 30) + 64'd500000000) / 64'd1000000000;
            for (int j = 0; j <= LOG_TABLE_DEPTH; j++)
            begin
                t = (longint'(j) << 30) / LOG_TABLE_DEPTH;
                y = 64'd1073741824 + ((t * e1) >> 30);
                f = (ln_q30(y) + 64'd512) >> 10;
                log_tab[j] = (f > 64'd1048576) ? 64'd1048576 : f;
            end
        endfunction

        function longint q16(longint unsigned n);
            return longint'((n * 64'd65536 + 64'd5000000000) / 64'd10000000000);
        endfunction

        function longint cent(longint unsigned n, int bits);
            return longint'(((n << bits) + 64'd50) / 64'd100);
        endfunction

        // Round to nearest with halves going up; >>> floors negatives.
        function longint round_shift(longint v, int s);
            return (v + (longint'(1) << (s - 1))) >>> s;
        endfunction

        function longint unsigned floor_root(longint unsigned n, bit cube);
            longint unsigned lo, hi, mid, pw;
            lo = 0;
            hi = 64'd1 << 21;
            while (hi - lo > 1)
            begin
                mid = (lo + hi) / 2;
                pw  = cube ? mid * mid * mid : mid * mid;
                if (pw <= n)
                    lo = mid;
                else
                    hi = mid;
            end
            return lo;
        endfunction

        // Natural log in Q30 through the atanh series.
        function longint unsigned ln_q30(longint unsigned y);
            longint unsigned z, z2, term, sum;
            z    = ((y - 64'd1073741824) << 30) / (y + 64'd1073741824);
            z2   = (z * z) >> 30;
            term = z;
            sum  = 0;
            for (int k = 0; k < 24; k++)
            begin
                sum  = sum + term / longint'(2 * k + 1);
                term = (term * z2) >> 30;
            end
            return 2 * sum;
        endfunction

        // Linear interpolation between table nodes; the top node stands alone.
        function longint table_read(bit from_gamma, longint v, int fbits);
            longint depth, pos, node, frac, lo_v, hi_v;
            depth = from_gamma ? GAMMA_TABLE_DEPTH : LOG_TABLE_DEPTH;
            pos   = v * depth;
            node  = pos >>> fbits;
            frac  = pos & ((longint'(1) << fbits) - 1);
            if (node >= depth)
                return from_gamma ? gamma_tab[depth] : log_tab[depth];
            lo_v = from_gamma ? gamma_tab[node] : log_tab[node];
            hi_v = from_gamma ? gamma_tab[node+1] : log_tab[node+1];
            return lo_v + (((hi_v - lo_v) * frac) >>> fbits);
        endfunction

        // sRGB transfer curve on a Q24 linear value.
        function logic [15:0] encode(longint v);
            longint o;
            if (v < 0)
                v = 0;
            if (v > (longint'(1) << 24))
                v = longint'(1) << 24;
            if (v <= 52526)
                return 16'(round_shift(v * 846712, 24));
            o = round_shift(table_read(1'b1, v, 24) * 70798771, 30) - 3604;
            if (o < 0)
                o = 0;
            if (o > 65535)
                o = 65535;
            return 16'(o);
        endfunction

        function pixel_t oklab_pixel(longint l, longint a, longint b);
            longint lms[3];
            longint x, acc;
            logic [15:0] ch[3];
            pixel_t px;
            for (int k = 0; k < 3; k++)
            begin
                x = l + round_shift(lab_c[k][0] * a + lab_c[k][1] * b, 16);
                lms[k] = round_shift(x * x * x, 18);
            end
            for (int k = 0; k < 3; k++)
            begin
                acc = 0;
                for (int j = 0; j < 3; j++)
                    acc += rgb_c[k][j] * lms[j];
                ch[k] = encode(round_shift(acc, 16));
            end
            px.r = ch[0];
            px.g = ch[1];
            px.b = ch[2];
            return px;
        endfunction

        function void note(logic kind, logic signed [15:0] l, logic signed [15:0] a,
                           logic signed [15:0] b, logic [15:0] disp);
            longint t, f;
            if (kind == REQ_OKLAB)
                owed.push_back(oklab_pixel(l, a, b));
            else
            begin
                t = disp;
                if (t > 32768)
                    t = 32768;
                f = table_read(1'b0, t, 15);
                owed.push_back(oklab_pixel(
                    round_shift(cent(15, 36) + cent(70, 16) * f, 22),
                    round_shift(-cent(5, 36) + cent(8, 16) * f, 22),
                    round_shift(-cent(10, 36) + cent(20, 16) * f, 22)));
            end
        endfunction

        function void check(logic [15:0] r, logic [15:0] g, logic [15:0] b);
            pixel_t px;
            if (owed.size() == 0)
            begin
                $display("%0t: unexpected pixel r=%0d g=%0d b=%0d", $time, r, g, b);
                errors++;
                return;
            end
            px = owed.pop_front();
            checked++;
            if (r !== px.r)
            begin
                $display("%0t: red expected %0d actual %0d", $time, px.r, r);
                errors++;
            end
            if (g !== px.g)
            begin
                $display("%0t: green expected %0d actual %0d", $time, px.g, g);
                errors++;
            end
            if (b !== px.b)
            begin
                $display("%0t: blue expected %0d actual %0d", $time, px.b, b);
                errors++;
            end
        endfunction
    endclass

    logic                     clk;
    logic                     rst_n;
    logic                     req_valid;
    logic                     req_stall;
    logic                     req_type;
    logic signed [LAB_W-1:0]  lightness;
    logic signed [LAB_W-1:0]  axis_green_red;
    logic signed [LAB_W-1:0]  axis_blue_yellow;
    logic [DISP_W-1:0]        display_level;
    logic                     rsp_valid;
    logic                     rsp_stall;
    logic [PIX_W-1:0]         red;
    logic [PIX_W-1:0]         green;
    logic [PIX_W-1:0]         blue;

    pixel_scoreboard sb;
    bit              gaps_on;
    bit              hold_request;
    int              idle_count;
    int              oklab_sent;
    int              colormap_sent;

    oklab_to_srgb_converter dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .req_valid        (req_valid),
        .req_stall        (req_stall),
        .req_type         (req_type),
        .lightness        (lightness),
        .axis_green_red   (axis_green_red),
        .axis_blue_yellow (axis_blue_yellow),
        .display_level    (display_level),
        .rsp_valid        (rsp_valid),
        .rsp_stall        (rsp_stall),
        .red              (red),
        .green            (green),
        .blue             (blue)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Both channels are observed at the rising edge. Inputs only move at the
    // falling edge, so what we read here is exactly what the converter saw.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && !req_stall)
                sb.note(req_type, lightness, axis_green_red, axis_blue_yellow,
                        display_level);
            if (rsp_valid && !rsp_stall)
                sb.check(red, green, blue);
            // The watchdog restarts on any transfer in either direction.
            if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
                idle_count <= 0;
            else
                idle_count <= idle_count + 1;
            if (idle_count >= WATCHDOG_LIMIT)
            begin
                $display("%0t: watchdog expired with %0d pixels owed", $time,
                         sb.owed.size());
                $display("simulation failed");
                $finish;
            end
        end
    end

    // The receiver stalls in short random bursts while gaps are on, and holds
    // off for one long counted stretch when the sender asks for it, so that
    // the pipeline fills and pushes back on the input side.
    initial
    begin
        int n;
        rsp_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                rsp_stall = 1'b1;
                for (n = 0; n < HOLD_CYCLES; n++)
                    @(negedge clk);
                hold_request = 1'b0;
                rsp_stall = 1'b0;
            end
            else if (gaps_on && $urandom_range(0, 5) == 0)
            begin
                rsp_stall = 1'b1;
                n = $urandom_range(1, 7);
                repeat (n - 1) @(negedge clk);
            end
            else
                rsp_stall = 1'b0;
        end
    end

    // Offers one item and waits for its transfer. Called right after a
    // falling edge; returns right after the falling edge that follows its transfer.
    task automatic send_item(logic kind, logic signed [15:0] l, logic signed [15:0] a,
                             logic signed [15:0] b, logic [15:0] disp);
        int gap;
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            req_valid = 1'b0;
            gap = $urandom_range(1, 7);
            repeat (gap) @(negedge clk);
        end
        req_type         = kind;
        lightness        = l;
        axis_green_red   = a;
        axis_blue_yellow = b;
        display_level    = disp;
        req_valid        = 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        if (kind == REQ_OKLAB)
            oklab_sent++;
        else
            colormap_sent++;
        @(negedge clk);
    endtask

    // Random item: mostly in-gamut colors and colormap values in range, with
    // a share of full-range noise so that every input bit toggles.
    task automatic send_random();
        logic [15:0] l, a, b, d;
        int pick;
        pick = $urandom_range(0, 9);
        d = $urandom;
        l = $urandom;
        a = $urandom;
        b = $urandom;
        if (pick < 4)
        begin
            if ($urandom_range(0, 4) != 0)
                d = $urandom_range(0, 32768);
            send_item(REQ_COLORMAP, l, a, b, d);
        end
        else if (pick < 8)
        begin
            l = $urandom_range(0, 16384);
            a = $signed($urandom_range(0, 12000)) - 6000;
            b = $signed($urandom_range(0, 12000)) - 6000;
            send_item(REQ_OKLAB, l, a, b, d);
        end
        else
            send_item(REQ_OKLAB, l, a, b, d);
    endtask

    initial
    begin
        sb               = new();
        rst_n            = 1'b0;
        req_valid        = 1'b0;
        req_type         = REQ_OKLAB;
        lightness        = '0;
        axis_green_red   = '0;
        axis_blue_yellow = '0;
        display_level    = '0;
        gaps_on          = 1'b1;
        hold_request     = 1'b0;
        idle_count       = 0;
        oklab_sent       = 0;
        colormap_sent    = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: black, white, field extremes, the linear segment of the
        // curve, out-of-gamut colors, and the colormap at both ends, above
        // one, exactly on table nodes, with the unused fields at extremes.
        send_item(REQ_OKLAB, 16'sd0, 16'sd0, 16'sd0, 16'hFFFF);
        send_item(REQ_OKLAB, 16'sd16384, 16'sd0, 16'sd0, 16'h0000);
        send_item(REQ_OKLAB, 16'sd32767, 16'sd32767, 16'sd32767, 16'hFFFF);
        send_item(REQ_OKLAB, -16'sd32768, -16'sd32768, -16'sd32768, 16'h0000);
        send_item(REQ_OKLAB, 16'sd32767, -16'sd32768, 16'sd32767, 16'h8000);
        send_item(REQ_OKLAB, 16'sd8192, 16'sd32767, -16'sd32768, 16'h7FFF);
        send_item(REQ_OKLAB, 16'sd2000, 16'sd0, 16'sd0, 16'h0000);
        send_item(REQ_OKLAB, 16'sd2400, 16'sd100, -16'sd100, 16'h0000);
        send_item(REQ_OKLAB, 16'sd10000, 16'sd6000, 16'sd6000, 16'h0000);
        send_item(REQ_OKLAB, 16'sd10000, -16'sd6000, -16'sd6000, 16'h0000);
        send_item(REQ_OKLAB, 16'sd1, -16'sd1, 16'sd1, 16'h0001);
        send_item(REQ_COLORMAP, 16'sd0, 16'sd0, 16'sd0, 16'd0);
        send_item(REQ_COLORMAP, 16'sd32767, 16'sd32767, 16'sd32767, 16'd32768);
        send_item(REQ_COLORMAP, -16'sd32768, -16'sd32768, -16'sd32768, 16'd65535);
        send_item(REQ_COLORMAP, 16'sd0, 16'sd0, 16'sd0, 16'd32769);
        send_item(REQ_COLORMAP, 16'sd0, 16'sd0, 16'sd0, 16'd32767);
        send_item(REQ_COLORMAP, 16'sd0, 16'sd0, 16'sd0, 16'd16384);
        send_item(REQ_COLORMAP, 16'sd0, 16'sd0, 16'sd0, 16'd128);
        send_item(REQ_COLORMAP, 16'sd0, 16'sd0, 16'sd0, 16'd1);
        send_item(REQ_COLORMAP, 16'sd0, 16'sd0, 16'sd0, 16'd40000);

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            // Ask for the long receiver hold-off and keep offering items.
            if (i == 300)
                hold_request = 1'b1;
            // Let the pipeline run dry once before carrying on.
            if (i == 600)
            begin
                req_valid = 1'b0;
                while (sb.owed.size() != 0)
                    @(negedge clk);
            end
            if (i == RANDOM_ITEMS - QUIET_TAIL)
                gaps_on = 1'b0;
            send_random();
        end
        req_valid = 1'b0;

        while (sb.owed.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Converted %0d Oklab items and %0d colormap items, %0d pixels checked.",
                 oklab_sent, colormap_sent, sb.checked);
        if (sb.errors == 0 && sb.owed.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
